>>> rtl/mqtt_packet_deframer_defines.svh
// assertion macros used by the deframer parser
// no dependencies; taken in by `include where checks are written
`ifndef MQTT_PACKET_DEFRAMER_DEFINES_SVH
`define MQTT_PACKET_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpd check failed");

// next-cycle implication, checked outside reset
`define MPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpd check failed");

`endif

>>> rtl/mpd_pkg.sv
// types and constants of the mqtt packet deframer
// no dependencies; used by every module and the testbench
`default_nettype none

package mpd_pkg;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2
    } t_phase;

    localparam logic [3:0] TYPE_CONNACK = 4'h2;
    localparam logic [3:0] TYPE_PUBLISH = 4'h3;
    localparam logic [3:0] TYPE_SUBACK  = 4'h9;

    localparam int         LEN_CAP       = 256;
    localparam logic [8:0] MAX_LEN_RESET = 9'd256;
    localparam logic [1:0] VARINT_LAST   = 2'd3;

    typedef struct packed {
        logic [3:0] packet_type;
        logic [3:0] header_flags;
        logic [7:0] body_offset;
        logic [7:0] body_byte;
        logic       last_of_packet;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_res_push;

endpackage

`default_nettype wire

>>> rtl/mpd_if.sv
// valid/ready channel interfaces for received bytes and body results
// depends on nothing but the transfer protocol
`default_nettype none

interface mpd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mpd_body_if;
    logic       valid;
    logic       ready;
    logic [3:0] packet_type;
    logic [3:0] header_flags;
    logic [7:0] body_offset;
    logic [7:0] body_byte;
    logic       last_of_packet;

    modport source (output valid, output packet_type, output header_flags,
                    output body_offset, output body_byte, output last_of_packet,
                    input ready);
    modport sink   (input valid, input packet_type, input header_flags,
                    input body_offset, input body_byte, input last_of_packet,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/mqtt_packet_deframer.sv
// top level of the mqtt 3.1.1 packet deframer
// depends on mpd_pkg, mpd_if, mpd_in_stage, mpd_parser and mpd_out_stage
//
// i_rx carries the inbound byte stream, one byte per transfer. o_body carries
// one transfer per body byte of CONNACK, SUBACK and PUBLISH packets, tagged
// with packet type, header flags, offset in the body and a last marker.
// Header and length bytes, bodies of other types and abandoned packets give
// no transfer. i_cfg_wr_en / i_cfg_wr_data write the body length limit; the
// limit in force is the smallest of that value, MAX_BODY and 256.
// A byte accepted on i_rx goes into the input register, is parsed
// combinationally from there, and its result is held in the result register,
// which drives o_body. Throughput: one byte per cycle while o_body does not
// stall, set by the combinational parse between the two registers.
// Reset (synchronous, active low) empties both registers, returns the parser
// to the header phase and sets the limit to 256.
// When o_body stalls, the result register holds; a byte that produces no
// result still moves through, and a byte that would produce one waits in the
// input register, which then holds i_rx.ready low.
`default_nettype none

module mqtt_packet_deframer #(
    parameter int MAX_BODY = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    mpd_rx_if.sink          i_rx,
    mpd_body_if.source      o_body,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [8:0] i_cfg_wr_data
);
    import mpd_pkg::*;

    t_in_item  w_item;
    t_res_push w_push;
    logic      w_take;
    logic      w_free;

    mpd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (w_take),
        .o_item  (w_item)
    );

    mpd_parser #(
        .MAX_BODY (MAX_BODY)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (w_item),
        .o_take        (w_take),
        .i_res_ready   (w_free),
        .o_push        (w_push)
    );

    mpd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_free  (w_free),
        .o_body  (o_body)
    );

endmodule

`default_nettype wire

>>> rtl/mpd_in_stage.sv
// input register of the deframer: holds one received byte until parsed
// depends on mpd_pkg and mpd_rx_if
`default_nettype none

module mpd_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    mpd_rx_if.sink             i_rx,
    input  wire logic          i_take,
    output mpd_pkg::t_in_item  o_item
);
    import mpd_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;

    assign i_rx.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_item.valid   = r_valid;
    assign o_item.rx_byte = r_byte;

endmodule

`default_nettype wire

>>> rtl/mpd_parser.sv
// fixed header and remaining-length parser with body byte tagging
// depends on mpd_pkg and mqtt_packet_deframer_defines.svh
`default_nettype none

`include "mqtt_packet_deframer_defines.svh"

module mpd_parser #(
    parameter int MAX_BODY = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [8:0]         i_cfg_wr_data,
    input  wire mpd_pkg::t_in_item  i_item,
    output logic                    o_take,
    input  wire logic               i_res_ready,
    output mpd_pkg::t_res_push      o_push
);
    import mpd_pkg::*;

    localparam int CAP = (MAX_BODY < LEN_CAP) ? MAX_BODY : LEN_CAP;

    t_phase     r_phase, n_phase;
    logic [7:0] r_header, n_header;
    logic [8:0] r_remaining, n_remaining;
    logic [1:0] r_idx, n_idx;
    logic [7:0] r_pos, n_pos;
    logic [8:0] r_max_len;

    logic [8:0]  w_limit;
    logic [4:0]  w_shift;
    logic [27:0] w_shifted;
    logic [10:0] w_sum;
    logic        w_over;
    logic        w_last;
    logic        w_emit;

    assign w_limit   = (r_max_len < 9'(CAP)) ? r_max_len : 9'(CAP);
    assign w_shift   = {1'b0, r_idx, 2'b00} + {1'b0, r_idx, 2'b00}
                     - {3'b000, r_idx};
    assign w_shifted = {21'd0, i_item.rx_byte[6:0]} << w_shift;
    assign w_sum     = {2'b00, r_remaining} + {1'b0, w_shifted[9:0]};
    assign w_over    = (|w_shifted[27:10]) || (w_sum > {2'b00, w_limit});
    assign w_last    = r_remaining <= 9'd1;

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_header    = r_header;
        n_remaining = r_remaining;
        n_idx       = r_idx;
        n_pos       = r_pos;
        if (o_take) begin
            case (r_phase)
                PH_LENGTH: begin
                    if (w_over) begin
                        n_phase = PH_HEADER;
                    end else begin
                        n_remaining = w_sum[8:0];
                        if (!i_item.rx_byte[7]) begin
                            n_phase = (w_sum[8:0] != 9'd0) ? PH_BODY : PH_HEADER;
                        end else if (r_idx == VARINT_LAST) begin
                            n_phase = PH_HEADER;
                        end else begin
                            n_idx = r_idx + 2'd1;
                        end
                    end
                end
                PH_BODY: begin
                    n_pos = r_pos + 8'd1;
                    if (w_last) begin
                        n_remaining = 9'd0;
                        n_phase     = PH_HEADER;
                    end else begin
                        n_remaining = r_remaining - 9'd1;
                    end
                end
                default: begin
                    n_header    = i_item.rx_byte;
                    n_remaining = 9'd0;
                    n_idx       = 2'd0;
                    n_pos       = 8'd0;
                    n_phase     = PH_LENGTH;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        w_emit = 1'b0;
        case (r_phase)
            PH_BODY: begin
                w_emit = r_header[7:4] inside {TYPE_CONNACK, TYPE_PUBLISH, TYPE_SUBACK};
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
        o_take                   = i_item.valid && (!w_emit || i_res_ready);
        o_push.valid             = i_item.valid && w_emit && i_res_ready;
        o_push.data.packet_type  = r_header[7:4];
        o_push.data.header_flags = r_header[3:0];
        o_push.data.body_offset  = r_pos;
        o_push.data.body_byte    = i_item.rx_byte;
        o_push.data.last_of_packet = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_header    <= 8'd0;
            r_remaining <= 9'd0;
            r_idx       <= 2'd0;
            r_pos       <= 8'd0;
        end else begin
            r_phase     <= n_phase;
            r_header    <= n_header;
            r_remaining <= n_remaining;
            r_idx       <= n_idx;
            r_pos       <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_len <= i_cfg_wr_data;
        end
    end

    `MPD_ASSERT_IMPL(a_body_nonempty, i_clk, i_rst_n, r_phase == PH_BODY, r_remaining != 9'd0)
    `MPD_ASSERT_IMPL(a_push_in_body, i_clk, i_rst_n, o_push.valid, r_phase == PH_BODY && o_take)
    `MPD_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_take && r_phase == PH_BODY && w_last, r_phase == PH_HEADER)
    `MPD_ASSERT_IMPL(a_len_capped, i_clk, i_rst_n, r_phase == PH_LENGTH, r_remaining <= 9'(CAP))

endmodule

`default_nettype wire

>>> rtl/mpd_out_stage.sv
// result register of the deframer: holds one body byte until transferred
// depends on mpd_pkg and mpd_body_if
`default_nettype none

module mpd_out_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire mpd_pkg::t_res_push  i_push,
    output logic                     o_free,
    mpd_body_if.source               o_body
);
    import mpd_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_free = !r_valid || o_body.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_data <= i_push.data;
        end
    end

    assign o_body.valid          = r_valid;
    assign o_body.packet_type    = r_data.packet_type;
    assign o_body.header_flags   = r_data.header_flags;
    assign o_body.body_offset    = r_data.body_offset;
    assign o_body.body_byte      = r_data.body_byte;
    assign o_body.last_of_packet = r_data.last_of_packet;

endmodule

`default_nettype wire

>>> test/testbench.sv
// self-checking testbench of mqtt_packet_deframer
// depends on mpd_pkg, mpd_if and the deframer rtl
// a byte-level parser model predicts each body transfer; the monitor compares them in order
`default_nettype none

module testbench;
    import mpd_pkg::*;

    localparam int DUT_MAX_BODY = 256;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [8:0] i_cfg_wr_data;

    mpd_rx_if   rx_if ();
    mpd_body_if body_if ();

    mqtt_packet_deframer #(
        .MAX_BODY(DUT_MAX_BODY)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (rx_if),
        .o_body       (body_if),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    always #2 i_clk = ~i_clk;

    // parser model state
    t_phase     prs_phase;
    logic [7:0] prs_header;
    logic [8:0] prs_remaining;
    logic [1:0] prs_len_idx;
    logic [7:0] prs_body_pos;
    logic [8:0] prs_max_len;

    logic [7:0] rx_pending_q[$];
    t_result    body_expect_q[$];
    t_result    exp_res;

    int  rx_queued;
    int  rx_accepted;
    int  rx_gap_left;
    bit  rx_no_idle;
    int  sink_stall;
    bit  sink_no_stall;
    int  fail_cnt;
    int  cycle_cnt;

    function automatic int limit_in_force();
        int lim;
        lim = prs_max_len;
        if (lim > DUT_MAX_BODY) lim = DUT_MAX_BODY;
        if (lim > LEN_CAP) lim = LEN_CAP;
        return lim;
    endfunction

    task automatic predict_byte(input logic [7:0] c);
        int unsigned total;
        logic [3:0]  ptype;
        logic        last;
        t_result     res;
        case (prs_phase)
            PH_LENGTH: begin
                total = prs_remaining + (int'(c[6:0]) << (7 * prs_len_idx));
                if (total > limit_in_force()) begin
                    prs_phase = PH_HEADER;
                end else begin
                    prs_remaining = total[8:0];
                    if (!c[7]) begin
                        prs_phase = (prs_remaining != 0) ? PH_BODY : PH_HEADER;
                    end else if (prs_len_idx >= VARINT_LAST) begin
                        prs_phase = PH_HEADER;
                    end else begin
                        prs_len_idx = prs_len_idx + 2'd1;
                    end
                end
            end
            PH_BODY: begin
                ptype = prs_header[7:4];
                last  = (prs_remaining <= 9'd1);
                if (ptype == TYPE_CONNACK || ptype == TYPE_SUBACK || ptype == TYPE_PUBLISH) begin
                    res.packet_type    = ptype;
                    res.header_flags   = prs_header[3:0];
                    res.body_offset    = prs_body_pos;
                    res.body_byte      = c;
                    res.last_of_packet = last;
                    body_expect_q.push_back(res);
                end
                prs_body_pos = prs_body_pos + 8'd1;
                if (last) begin
                    prs_remaining = 9'd0;
                    prs_phase     = PH_HEADER;
                end else begin
                    prs_remaining = prs_remaining - 9'd1;
                end
            end
            default: begin
                prs_header    = c;
                prs_remaining = 9'd0;
                prs_len_idx   = 2'd0;
                prs_body_pos  = 8'd0;
                prs_phase     = PH_LENGTH;
            end
        endcase
    endtask

    task automatic push_rx(input logic [7:0] b);
        rx_pending_q.push_back(b);
        rx_queued++;
    endtask

    // one packet, mostly well formed, sometimes noise or a broken length field
    task automatic add_packet(input int lim);
        int         r;
        int         len;
        int         tmp;
        int         pad;
        logic [3:0] ptype;
        logic [6:0] grp[$];
        r = $urandom_range(0, 99);
        if (r < 8) begin
            repeat ($urandom_range(1, 3)) push_rx(8'($urandom));
            return;
        end
        case ($urandom_range(0, 4))
            0:       ptype = TYPE_CONNACK;
            1:       ptype = TYPE_SUBACK;
            2:       ptype = TYPE_PUBLISH;
            default: ptype = 4'($urandom);
        endcase
        push_rx({ptype, 4'($urandom)});
        r = $urandom_range(0, 99);
        if (r < 5) begin
            // continuation bit still set on the fourth length byte
            push_rx(8'h80 | 8'($urandom_range(0, (lim < 127) ? lim : 127)));
            repeat (3) push_rx(8'h80);
            return;
        end
        if (r < 75)      len = $urandom_range(0, (lim < 12) ? lim : 12);
        else if (r < 85) len = $urandom_range(0, (lim < 40) ? lim : 40);
        else if (r < 88) len = lim;
        else             len = lim + $urandom_range(1, 40);
        tmp = len;
        do begin
            grp.push_back(7'(tmp & 127));
            tmp = tmp >> 7;
        end while (tmp != 0);
        if ($urandom_range(0, 4) == 0) begin
            pad = $urandom_range(0, 4 - grp.size());
            repeat (pad) grp.push_back(7'd0);
        end
        foreach (grp[i]) push_rx({(i != grp.size() - 1), grp[i]});
        if (len <= lim) repeat (len) push_rx(8'($urandom));
    endtask

    task automatic wait_drained();
        while (rx_accepted != rx_queued || body_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [8:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        prs_max_len    = v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
            rx_gap_left  = 0;
        end else begin
            if (rx_if.valid && rx_if.ready) begin
                predict_byte(rx_if.rx_byte);
                rx_accepted++;
            end
            if (!rx_if.valid || rx_if.ready) begin
                if (rx_gap_left != 0) begin
                    rx_if.valid <= 1'b0;
                    rx_gap_left--;
                end else if (rx_pending_q.size() != 0) begin
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= rx_pending_q.pop_front();
                    if ($urandom_range(0, 63) == 0) rx_no_idle = !rx_no_idle;
                    rx_gap_left = rx_no_idle ? 0 : $urandom_range(0, 8);
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    // body transfer monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            body_if.ready <= 1'b0;
            sink_stall     = 0;
        end else begin
            if (body_if.valid && body_if.ready) begin
                if (body_expect_q.size() == 0) begin
                    $error("unexpected body transfer offset %0d byte %0h",
                           body_if.body_offset, body_if.body_byte);
                    fail_cnt++;
                end else begin
                    exp_res = body_expect_q.pop_front();
                    if (body_if.packet_type !== exp_res.packet_type) begin
                        $error("packet_type expected %0h got %0h",
                               exp_res.packet_type, body_if.packet_type);
                        fail_cnt++;
                    end
                    if (body_if.header_flags !== exp_res.header_flags) begin
                        $error("header_flags expected %0h got %0h",
                               exp_res.header_flags, body_if.header_flags);
                        fail_cnt++;
                    end
                    if (body_if.body_offset !== exp_res.body_offset) begin
                        $error("body_offset expected %0d got %0d",
                               exp_res.body_offset, body_if.body_offset);
                        fail_cnt++;
                    end
                    if (body_if.body_byte !== exp_res.body_byte) begin
                        $error("body_byte expected %0h got %0h",
                               exp_res.body_byte, body_if.body_byte);
                        fail_cnt++;
                    end
                    if (body_if.last_of_packet !== exp_res.last_of_packet) begin
                        $error("last_of_packet expected %0b got %0b",
                               exp_res.last_of_packet, body_if.last_of_packet);
                        fail_cnt++;
                    end
                end
                if ($urandom_range(0, 63) == 0) sink_no_stall = !sink_no_stall;
                sink_stall = sink_no_stall ? 0 : $urandom_range(0, 8);
            end else if (sink_stall != 0) begin
                sink_stall--;
            end
            body_if.ready <= (sink_stall == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [7:0] directed_bytes[];
        logic [8:0] limit_vals[];
        int         target;

        directed_bytes = '{
            8'h3F, 8'h02, 8'h00, 8'hFF,
            8'h20, 8'h00,
            8'h90, 8'h80, 8'h00,
            8'h30, 8'h80, 8'h80, 8'h80, 8'h80,
            8'h30, 8'h81, 8'h7F,
            8'hF0, 8'h01, 8'hAA,
            8'h92, 8'h01, 8'h55
        };
        limit_vals = '{9'd1, 9'd2, 9'd0, 9'd511, 9'd300, 9'd0, 9'd256};

        rx_if.valid     = 1'b0;
        rx_if.rx_byte   = 8'd0;
        body_if.ready   = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = 9'd0;
        i_rst_n         = 1'b0;
        prs_phase       = PH_HEADER;
        prs_header      = 8'd0;
        prs_remaining   = 9'd0;
        prs_len_idx     = 2'd0;
        prs_body_pos    = 8'd0;
        prs_max_len     = MAX_LEN_RESET;
        rx_no_idle      = 1'b0;
        sink_no_stall   = 1'b0;
        limit_vals[5]   = 9'($urandom_range(3, 255));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, zero length, padded length, overlong varint, over limit, other type
        foreach (directed_bytes[i]) push_rx(directed_bytes[i]);
        wait_drained();

        foreach (limit_vals[k]) begin
            write_limit(limit_vals[k]);
            target = rx_queued + ((limit_vals[k] == 9'd0) ? 120 : 260);
            while (rx_queued < target) add_packet(limit_in_force());
            wait_drained();
        end

        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);
        if (body_expect_q.size() != 0) begin
            $error("%0d body transfers never arrived", body_expect_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/mpd_pkg.sv
rtl/mpd_if.sv
rtl/mpd_in_stage.sv
rtl/mpd_parser.sv
rtl/mpd_out_stage.sv
rtl/mqtt_packet_deframer.sv
test/testbench.sv
